// ----- design/mandelbrot_escape_time_core_defines.svh -----
// Assertion shorthands for the escape-time core checkers.
`ifndef MANDELBROT_ESCAPE_TIME_CORE_DEFINES_SVH
`define MANDELBROT_ESCAPE_TIME_CORE_DEFINES_SVH

// Consequent checked in the cycle after the antecedent.
`define MET_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("escape-time core check failed");

// Consequent checked in the same cycle as the antecedent.
`define MET_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("escape-time core check failed");

`endif

// ----- design/met_pkg.sv -----
`timescale 1ns / 1ps

package met_pkg;

	// Q4.28 coordinates
	localparam int FRAC_W   = 28;
	localparam int COORD_W  = 32;
	localparam int STEP_W   = 31;
	localparam int LIMIT_W  = 12;
	localparam int LINE_W   = 11;
	localparam int PIX_W    = 10;
	localparam int COUNT_W  = 8;

	// Shared multiplier operand and product widths
	localparam int MUL_W    = 31;
	localparam int PROD_W   = 2 * MUL_W;

	// z and c: 41-bit offset plus 32-bit origin plus square terms
	localparam int Z_W      = 45;
	// Scaled squares and cross product stay below 4.0 (2^30)
	localparam int SQ_W     = FRAC_W + 2;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_RE_MIN     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IM_MAX     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RE_STEP    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_IM_STEP    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH = 3'd5;

	localparam logic signed [COORD_W-1:0] RST_RE_MIN     = 32'shE000_0000;
	localparam logic signed [COORD_W-1:0] RST_IM_MAX     = 32'sh1800_0000;
	localparam logic [STEP_W-1:0]         RST_RE_STEP    = 31'h000C_0000;
	localparam logic [STEP_W-1:0]         RST_IM_STEP    = 31'h000C_0000;
	localparam logic [LIMIT_W-1:0]        RST_ITER_LIMIT = 12'd255;
	localparam logic [LINE_W-1:0]         RST_LINE_WIDTH = 11'd1024;

	// Escape bound 4.0 on the sum of squares
	localparam logic [SQ_W:0] FOUR = (SQ_W+1)'(1) << (FRAC_W + 2);

	typedef struct packed {
		logic signed [COORD_W-1:0] re_min;
		logic signed [COORD_W-1:0] im_max;
		logic [STEP_W-1:0]         re_step;
		logic [STEP_W-1:0]         im_step;
		logic [LIMIT_W-1:0]        iteration_limit;
		logic [LINE_W-1:0]         line_width;
	} cfg_t;

endpackage

// ----- design/met_mul.sv -----
`timescale 1ns / 1ps

module met_mul
	import met_pkg::*;
(
	input  logic              clk,
	input  logic [MUL_W-1:0]  a,
	input  logic [MUL_W-1:0]  b,
	output logic [PROD_W-1:0] prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(a) * PROD_W'(b);
	end

endmodule

// ----- design/met_cfg.sv -----
`timescale 1ns / 1ps

module met_cfg
	import met_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [CFG_DAT_W-1:0] wr_data,
	output cfg_t                 cfg_q
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.re_min          <= RST_RE_MIN;
			cfg_q.im_max          <= RST_IM_MAX;
			cfg_q.re_step         <= RST_RE_STEP;
			cfg_q.im_step         <= RST_IM_STEP;
			cfg_q.iteration_limit <= RST_ITER_LIMIT;
			cfg_q.line_width      <= RST_LINE_WIDTH;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_RE_MIN:     cfg_q.re_min          <= signed'(wr_data);
				REG_IM_MAX:     cfg_q.im_max          <= signed'(wr_data);
				REG_RE_STEP:    cfg_q.re_step         <= wr_data[STEP_W-1:0];
				REG_IM_STEP:    cfg_q.im_step         <= wr_data[STEP_W-1:0];
				REG_ITER_LIMIT: cfg_q.iteration_limit <= wr_data[LIMIT_W-1:0];
				REG_LINE_WIDTH: cfg_q.line_width      <= wr_data[LINE_W-1:0];
				default: ;  // drop writes to unmapped indexes
			endcase
		end
	end

endmodule

// ----- design/met_seq.sv -----
`timescale 1ns / 1ps

module met_seq
	import met_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [PIX_W-1:0]   column,
	input  logic [PIX_W-1:0]   row,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [COUNT_W-1:0] count,
	output logic               row_end,
	output logic [MUL_W-1:0]   mul_a,
	output logic [MUL_W-1:0]   mul_b,
	input  logic [PROD_W-1:0]  prod
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CR,
		ST_CI,
		ST_CI_LOAD,
		ST_CHECK,
		ST_SQ_I,
		ST_CROSS,
		ST_UPDATE
	} state_t;

	// Finished pixel waiting for the output register
	typedef enum logic {
		RES_NONE,
		RES_PEND
	} res_t;

	state_t                    state_q;
	res_t                      res_q;
	logic                      out_valid_q;
	logic [COUNT_W-1:0]        count_q;
	logic                      row_end_q;
	logic                      flag_q;
	logic [LIMIT_W-1:0]        n_q;

	logic [PIX_W-1:0]          col_q;
	logic [PIX_W-1:0]          row_q;
	logic signed [Z_W-1:0]     cr_q;
	logic signed [Z_W-1:0]     ci_q;
	logic signed [Z_W-1:0]     zr_q;
	logic signed [Z_W-1:0]     zi_q;
	logic [FRAC_W:0]           ar_q;
	logic [FRAC_W:0]           ai_q;
	logic [SQ_W-1:0]           sr_q;
	logic [SQ_W-1:0]           si_q;

	logic [Z_W-1:0]            ar_c;
	logic [Z_W-1:0]            ai_c;
	logic                      too_big;
	logic [SQ_W-1:0]           prod_sc;
	logic signed [Z_W-1:0]     offset;
	logic signed [Z_W-1:0]     cross2;
	logic                      accept;
	logic                      slot_free;

	assign accept    = in_valid && (state_q == ST_IDLE) && (res_q == RES_NONE);
	assign in_ready  = (state_q == ST_IDLE) && (res_q == RES_NONE);
	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign count     = count_q;
	assign row_end   = row_end_q;

	// Escape on either coordinate reaching 2.0
	assign ar_c    = zr_q[Z_W-1] ? Z_W'(-zr_q) : Z_W'(zr_q);
	assign ai_c    = zi_q[Z_W-1] ? Z_W'(-zi_q) : Z_W'(zi_q);
	assign too_big = (|ar_c[Z_W-1:FRAC_W+1]) || (|ai_c[Z_W-1:FRAC_W+1]);

	assign prod_sc = prod[FRAC_W +: SQ_W];
	assign offset  = signed'({1'b0, prod[Z_W-2:0]});
	assign cross2  = signed'(Z_W'({prod_sc, 1'b0}));

	always_comb begin
		unique case (state_q)
			ST_CR: begin
				mul_a = MUL_W'(col_q);
				mul_b = cfg.re_step;
			end
			ST_CI: begin
				mul_a = MUL_W'(row_q);
				mul_b = cfg.im_step;
			end
			ST_CHECK: begin
				mul_a = MUL_W'(ar_c[FRAC_W:0]);
				mul_b = MUL_W'(ar_c[FRAC_W:0]);
			end
			ST_SQ_I: begin
				mul_a = MUL_W'(ai_q);
				mul_b = MUL_W'(ai_q);
			end
			ST_CROSS: begin
				mul_a = MUL_W'(ar_q);
				mul_b = MUL_W'(ai_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Sequencer, iteration count and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_q       <= RES_NONE;
			out_valid_q <= 1'b0;
			count_q     <= '0;
			row_end_q   <= 1'b0;
			flag_q      <= 1'b0;
			n_q         <= '0;
		end else begin
			// Hand the finished pixel to the output register once it is free
			if (res_q == RES_PEND && slot_free) begin
				out_valid_q <= 1'b1;
				count_q     <= n_q[COUNT_W-1:0];
				row_end_q   <= flag_q;
				res_q       <= RES_NONE;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						n_q     <= '0;
						flag_q  <= (cfg.line_width != '0) &&
							((LINE_W'(column) + LINE_W'(1)) == cfg.line_width);
						state_q <= ST_CR;
					end
				end
				ST_CR:      state_q <= ST_CI;
				ST_CI:      state_q <= ST_CI_LOAD;
				ST_CI_LOAD: state_q <= ST_CHECK;
				ST_CHECK: begin
					if (n_q >= cfg.iteration_limit || too_big) begin
						res_q   <= RES_PEND;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_SQ_I;
					end
				end
				ST_SQ_I:    state_q <= ST_CROSS;
				ST_CROSS: begin
					if (({1'b0, prod_sc} + {1'b0, sr_q}) >= FOUR) begin
						res_q   <= RES_PEND;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					n_q     <= n_q + LIMIT_W'(1);
					state_q <= ST_CHECK;
				end
			endcase
		end
	end

	// Point and orbit datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					col_q <= column;
					row_q <= row;
					zr_q  <= '0;
					zi_q  <= '0;
				end
			end
			ST_CI: begin
				cr_q <= Z_W'(cfg.re_min) + offset;
			end
			ST_CI_LOAD: begin
				ci_q <= Z_W'(cfg.im_max) - offset;
			end
			ST_CHECK: begin
				ar_q <= ar_c[FRAC_W:0];
				ai_q <= ai_c[FRAC_W:0];
			end
			ST_SQ_I: begin
				sr_q <= prod_sc;
			end
			ST_CROSS: begin
				si_q <= prod_sc;
			end
			ST_UPDATE: begin
				zr_q <= signed'(Z_W'(sr_q)) - signed'(Z_W'(si_q)) + cr_q;
				zi_q <= ((zr_q[Z_W-1] ^ zi_q[Z_W-1]) ? -cross2 : cross2) + ci_q;
			end
			default: ;
		endcase
	end

endmodule

// ----- design/mandelbrot_escape_time_core.sv -----
`timescale 1ns / 1ps

// Mandelbrot escape-time engine: one (column, row) transaction in, one
// (count, row_end) transaction out. The point c = re_min + column*re_step
// + i*(im_max - row*im_step) is formed in Q17.28, then z = z*z + c runs from
// z = 0 until |z|^2 reaches 4.0 or iteration_limit steps are done (default
// limit 255); count is the step count modulo 256. All products go through one
// registered 31x31 multiplier: forming c takes two products, every iteration
// takes three products plus the update, and the exit is taken either at the
// start of an iteration or after its squares. in_ready is low from the time a
// pixel is taken until its result moves on, longer while the previous result
// still holds the output register; the result sits in an output register, so
// the next pixel is taken while the previous result still waits.
// Configuration writes are accepted every cycle and must only happen while
// the engine is idle.
module mandelbrot_escape_time_core
	import met_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [PIX_W-1:0]     column,
	input  logic [PIX_W-1:0]     row,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [COUNT_W-1:0]   count,
	output logic                 row_end
);

	cfg_t              cfg;
	logic [MUL_W-1:0]  mul_a;
	logic [MUL_W-1:0]  mul_b;
	logic [PROD_W-1:0] prod;

	assign cfg_ready = 1'b1;

	met_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg_q    (cfg)
	);

	met_mul u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod)
	);

	met_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.column    (column),
		.row       (row),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.count     (count),
		.row_end   (row_end),
		.mul_a     (mul_a),
		.mul_b     (mul_b),
		.prod      (prod)
	);

endmodule

// ----- design/met_chk.sv -----
`timescale 1ns / 1ps
`include "mandelbrot_escape_time_core_defines.svh"

module met_chk
	import met_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 cfg_ready,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic [COUNT_W-1:0]   count,
	input logic                 row_end
);

	// The engine is busy right after it takes a pixel
	`MET_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

	// A new result only shows up while the engine is idle and ready
	`MET_ASSERT_SAME(a_result_at_idle, $rose(out_valid), in_ready)

	// Configuration is never back-pressured
	`MET_ASSERT_SAME(a_cfg_always_ready, 1'b1, cfg_ready)

	// A stalled result holds its payload
	`MET_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(count) && $stable(row_end))

endmodule

bind mandelbrot_escape_time_core met_chk u_met_chk (.*);

// ----- tb/mandelbrot_escape_time_checker.sv -----
`timescale 1ns / 1ps

module mandelbrot_escape_time_checker
	import met_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic [PIX_W-1:0]     column,
	input  logic [PIX_W-1:0]     row,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic [COUNT_W-1:0]   count,
	input  logic                 row_end,
	output int                   fail_count,
	output int                   outstanding
);

	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic               row_end;
	} pixel_result_t;

	localparam longint unsigned Q_TWO  = 64'd2 << FRAC_W;
	localparam longint unsigned Q_FOUR = 64'd4 << FRAC_W;

	cfg_t          view_cfg;
	pixel_result_t pending_results[$];
	pixel_result_t want;

	function automatic longint unsigned magnitude(input longint v);
		if (v < 0)
			return -v;
		return v;
	endfunction

	// Exact wide product, then drop the fraction bits.
	function automatic longint unsigned q_mul(input longint unsigned a, input longint unsigned b);
		logic [127:0] wide;
		wide = {64'd0, a} * {64'd0, b};
		return wide[FRAC_W +: 64];
	endfunction

	function automatic pixel_result_t escape_result(input cfg_t s, input logic [PIX_W-1:0] col,
			input logic [PIX_W-1:0] rw);
		longint          cr, ci, zr, zi, cross_term;
		longint unsigned ar, ai, sr, si, p, col_w, row_w, re_step_w, im_step_w;
		int              n;
		logic            escaped;
		pixel_result_t   res;
		col_w = col;
		row_w = rw;
		re_step_w = s.re_step;
		im_step_w = s.im_step;
		cr = $signed(s.re_min);
		cr = cr + longint'(col_w * re_step_w);
		ci = $signed(s.im_max);
		ci = ci - longint'(row_w * im_step_w);
		zr = 0;
		zi = 0;
		n = 0;
		escaped = 1'b0;
		while (n < s.iteration_limit && !escaped) begin
			ar = magnitude(zr);
			ai = magnitude(zi);
			if (ar >= Q_TWO || ai >= Q_TWO) begin
				escaped = 1'b1;
			end else begin
				sr = q_mul(ar, ar);
				si = q_mul(ai, ai);
				if (sr + si >= Q_FOUR) begin
					escaped = 1'b1;
				end else begin
					// cross term is truncated on magnitudes, then signed
					p = q_mul(ar, ai);
					cross_term = ((zr < 0) != (zi < 0)) ? -longint'(p) : longint'(p);
					zr = longint'(sr) - longint'(si) + cr;
					zi = 2 * cross_term + ci;
					n++;
				end
			end
		end
		res.count = n[COUNT_W-1:0];
		res.row_end = (s.line_width != 0) && (({1'b0, col} + 11'd1) == s.line_width);
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			view_cfg = '{re_min: RST_RE_MIN, im_max: RST_IM_MAX, re_step: RST_RE_STEP,
				im_step: RST_IM_STEP, iteration_limit: RST_ITER_LIMIT,
				line_width: RST_LINE_WIDTH};
			pending_results.delete();
			fail_count = 0;
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_RE_MIN:     view_cfg.re_min = cfg_data;
					REG_IM_MAX:     view_cfg.im_max = cfg_data;
					REG_RE_STEP:    view_cfg.re_step = cfg_data[STEP_W-1:0];
					REG_IM_STEP:    view_cfg.im_step = cfg_data[STEP_W-1:0];
					REG_ITER_LIMIT: view_cfg.iteration_limit = cfg_data[LIMIT_W-1:0];
					REG_LINE_WIDTH: view_cfg.line_width = cfg_data[LINE_W-1:0];
					default: ;
				endcase
			end
			// retire the output before queueing a new pixel: a result never
			// belongs to a pixel taken at the same edge
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					$error("unexpected result transaction: count %0d, row_end %0d",
						count, row_end);
					fail_count++;
				end else begin
					want = pending_results.pop_front();
					if (count !== want.count) begin
						$error("count mismatch: expected %0d, actual %0d", want.count, count);
						fail_count++;
					end
					if (row_end !== want.row_end) begin
						$error("row_end mismatch: expected %0d, actual %0d",
							want.row_end, row_end);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready)
				pending_results.push_back(escape_result(view_cfg, column, row));
			outstanding <= pending_results.size();
		end
	end

endmodule

// ----- tb/mandelbrot_escape_time_core_tb.sv -----
`timescale 1ns / 1ps

module mandelbrot_escape_time_core_tb;
	import met_pkg::*;

	// indexes past the register file; writes to them must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

	localparam int STALL_LIMIT  = 100000;
	localparam int HOLD_CYCLES  = 800;
	localparam int PHASES       = 16;
	localparam int PHASE_PIXELS = 105;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [PIX_W-1:0]     column = '0;
	logic [PIX_W-1:0]     row = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [COUNT_W-1:0]   count;
	logic                 row_end;

	logic calm = 1'b0;
	logic hold_off_req = 1'b0;
	int   fail_count;
	int   outstanding;

	mandelbrot_escape_time_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.column    (column),
		.row       (row),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.count     (count),
		.row_end   (row_end)
	);

	mandelbrot_escape_time_checker result_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.column      (column),
		.row         (row),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.count       (count),
		.row_end     (row_end),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_setup(input logic [31:0] re_min, input logic [31:0] im_max,
			input logic [31:0] re_step, input logic [31:0] im_step,
			input logic [31:0] cap, input logic [31:0] lw);
		write_reg(REG_RE_MIN, re_min);
		write_reg(REG_IM_MAX, im_max);
		write_reg(REG_RE_STEP, re_step);
		write_reg(REG_IM_STEP, im_step);
		write_reg(REG_ITER_LIMIT, cap);
		write_reg(REG_LINE_WIDTH, lw);
	endtask

	task automatic send_pixel(input logic [PIX_W-1:0] col, input logic [PIX_W-1:0] rw);
		while (!calm && $urandom_range(99) < 17) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		column <= col;
		row <= rw;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// Drop valid and wait until every queued pixel has come back.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		int lw, cap, span, seg, start, left, r, row_hi;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset window: corners, row end, a point that never escapes
		send_pixel(10'd0, 10'd0);
		send_pixel(10'd1023, 10'd1023);
		send_pixel(10'd683, 10'd512);
		send_pixel(10'd1023, 10'd0);
		send_pixel(10'd1022, 10'd5);
		send_pixel(10'd0, 10'd1023);
		send_pixel(10'd512, 10'd0);
		settle();

		write_reg(REG_ITER_LIMIT, 32'd0);
		send_pixel(10'd683, 10'd512);
		send_pixel(10'd1023, 10'd1023);
		settle();

		// limit reached: count wraps to 255, then to 0
		write_reg(REG_ITER_LIMIT, 32'd4095);
		send_pixel(10'd683, 10'd512);
		settle();
		write_reg(REG_ITER_LIMIT, 32'hFFFF_F100);
		send_pixel(10'd683, 10'd512);
		settle();

		// register extremes, zero line width
		apply_setup(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'd4095, 32'd0);
		send_pixel(10'd0, 10'd0);
		send_pixel(10'd1023, 10'd1023);
		send_pixel(10'd1023, 10'd512);
		settle();

		apply_setup(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0, 32'd1, 32'd1);
		send_pixel(10'd0, 10'd0);
		send_pixel(10'd1, 10'd0);
		send_pixel(10'd1023, 10'd1023);
		settle();

		write_reg(REG_SPARE_6, $urandom);
		write_reg(REG_SPARE_7, $urandom);
		send_pixel(10'd0, 10'd1023);
		settle();

		for (int ph = 0; ph < PHASES; ph++) begin
			calm <= (ph == 6);
			if (ph % 5 == 3) begin
				// arbitrary register contents, upper data bits random
				lw = $urandom_range(0, 2047);
				cap = $urandom_range(0, 300);
				row_hi = 1023;
				apply_setup($urandom, $urandom, $urandom, $urandom,
					{20'($urandom), 12'(cap)}, {21'($urandom), 11'(lw)});
			end else begin
				r = $urandom_range(99);
				if (r < 70)
					lw = $urandom_range(1, 64);
				else if (r < 90)
					lw = $urandom_range(65, 1024);
				else begin
					case ($urandom_range(3))
						0: lw = 0;
						1: lw = 1;
						2: lw = 1024;
						default: lw = 2047;
					endcase
				end
				r = $urandom_range(99);
				if (ph == 1)
					cap = $urandom_range(0, 30);
				else if (r < 60)
					cap = $urandom_range(0, 40);
				else if (r < 90)
					cap = $urandom_range(41, 255);
				else
					cap = $urandom_range(256, 600);
				row_hi = 63;
				// window around the set, spanning 0.5 to 4.0 across one row
				span = $urandom_range(1 << 27, 1 << 30);
				apply_setup(32'(-int'($urandom_range(0, 671088640))),
					32'($urandom_range(0, 536870912)),
					32'(span / (lw == 0 ? 1 : lw)),
					32'($urandom_range(1 << 27, 1 << 30) / 64),
					{20'($urandom), 12'(cap)}, {21'($urandom), 11'(lw)});
			end

			left = PHASE_PIXELS;
			while (left > 0) begin
				if ($urandom_range(99) < 75) begin
					// scan the tail of a row, ending around its last pixel
					seg = $urandom_range(1, 16);
					if (seg > left)
						seg = left;
					start = lw - seg + int'($urandom_range(0, 2)) - 1;
					if (start < 0)
						start = 0;
					r = $urandom_range(0, row_hi);
					for (int k = 0; k < seg; k++)
						send_pixel(PIX_W'(start + k), PIX_W'(r));
					left -= seg;
				end else begin
					send_pixel(PIX_W'($urandom_range(0, 1023)), PIX_W'($urandom_range(0, 1023)));
					left--;
				end
				if (ph == 1 && left < PHASE_PIXELS - 10)
					hold_off_req <= 1'b1;
			end
			settle();
		end

		repeat (40) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// receiver: random stalls, one long hold-off so the engine backs up
	initial begin
		logic held;
		held = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_off_req && !held) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				out_ready <= calm || ($urandom_range(99) >= 17);
			end
		end
	end

	initial begin
		int stalled;
		stalled = 0;
		while (stalled < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				stalled = 0;
			else
				stalled++;
		end
		$display("TEST FAILED");
		$finish;
	end

endmodule
